### design/bsm_pkg.sv
// Shared constants and types for the bounding sphere merge block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bsm_pkg;

   // default raw coordinate width (signed fixed point, scale cancels out)
   localparam int CoordWidthDef = 32;

   typedef enum logic [2:0] {
      CaseFirstEmpty    = 3'd0,
      CaseSecondEmpty   = 3'd1,
      CaseFirstContains = 3'd2,
      CaseSecondContains = 3'd3,
      CaseMerged        = 3'd4
   } merge_case_type;

endpackage

`default_nettype wire

### design/bsm_isqrt.sv
// Pipelined floored integer square root, one root bit per register stage.
// Depends on bsm_pkg; sideband rides along with each item.
`default_nettype none

module bsm_isqrt
   import bsm_pkg::*;
#(
   parameter int RootWidth = CoordWidthDef + 1,
   parameter int SbWidth   = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     adv,
   input  wire logic                     in_vld,
   input  wire logic [2*RootWidth-1:0]   in_x,
   input  wire logic [SbWidth-1:0]       in_sb,
   output logic                          out_vld,
   output logic [RootWidth-1:0]          out_root,
   output logic [SbWidth-1:0]            out_sb
);

   localparam int XW  = 2 * RootWidth;
   localparam int RMW = RootWidth + 2;

   logic                 vld_ff  [RootWidth];
   logic [XW-1:0]        x_ff    [RootWidth];
   logic [RootWidth-1:0] root_ff [RootWidth];
   logic [RMW-1:0]       rem_ff  [RootWidth];
   logic [SbWidth-1:0]   sb_ff   [RootWidth];

   for (genvar s = 0; s < RootWidth; s++) begin : g_stg
      logic                 vld_cur;
      logic [XW-1:0]        x_cur;
      logic [RootWidth-1:0] root_cur;
      logic [RMW-1:0]       rem_cur;
      logic [SbWidth-1:0]   sb_cur;
      logic [RMW+1:0]       rem_sh;
      logic [RMW+1:0]       trial;
      logic [RMW+1:0]       diff;
      logic                 take;
      logic [RMW-1:0]       rem_in;

      if (s == 0) begin : g_head
         assign vld_cur  = in_vld;
         assign x_cur    = in_x;
         assign root_cur = '0;
         assign rem_cur  = '0;
         assign sb_cur   = in_sb;
      end else begin : g_body
         assign vld_cur  = vld_ff[s-1];
         assign x_cur    = x_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign sb_cur   = sb_ff[s-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {rem_cur, x_cur[XW-1 -: 2]};
      assign trial  = (RMW+2)'({root_cur, 2'b01});
      assign take   = (rem_sh >= trial);
      assign diff   = rem_sh - trial;
      assign rem_in = take ? diff[RMW-1:0] : rem_sh[RMW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[s]    <= x_cur << 2;
            root_ff[s] <= {root_cur[RootWidth-2:0], take};
            rem_ff[s]  <= rem_in;
            sb_ff[s]   <= sb_cur;
         end
      end
   end

   assign out_vld  = vld_ff[RootWidth-1];
   assign out_root = root_ff[RootWidth-1];
   assign out_sb   = sb_ff[RootWidth-1];

endmodule

`default_nettype wire

### design/bsm_div.sv
// Pipelined three-lane restoring divider sharing one divisor, one quotient
// bit per stage. Depends on bsm_pkg. Caller guarantees numerator top half < divisor.
`default_nettype none

module bsm_div
   import bsm_pkg::*;
#(
   parameter int QuoWidth = CoordWidthDef + 1,
   parameter int SbWidth  = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_vld,
   input  wire logic [2:0][2*QuoWidth-1:0]    in_num,
   input  wire logic [QuoWidth-1:0]           in_den,
   input  wire logic [SbWidth-1:0]            in_sb,
   output logic                               out_vld,
   output logic [2:0][QuoWidth-1:0]           out_quo,
   output logic [SbWidth-1:0]                 out_sb
);

   localparam int NW = 2 * QuoWidth;

   logic                    vld_ff [QuoWidth];
   logic [QuoWidth-1:0]     den_ff [QuoWidth];
   logic [SbWidth-1:0]      sb_ff  [QuoWidth];
   // upper half: partial remainder, lower half: dividend bits then quotient
   logic [2:0][NW-1:0]      wrk_ff [QuoWidth];

   for (genvar s = 0; s < QuoWidth; s++) begin : g_stg
      logic                 vld_cur;
      logic [QuoWidth-1:0]  den_cur;
      logic [SbWidth-1:0]   sb_cur;
      logic [2:0][NW-1:0]   wrk_cur;
      logic [2:0][NW-1:0]   wrk_in;

      if (s == 0) begin : g_head
         assign vld_cur = in_vld;
         assign den_cur = in_den;
         assign sb_cur  = in_sb;
         assign wrk_cur = in_num;
      end else begin : g_body
         assign vld_cur = vld_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign sb_cur  = sb_ff[s-1];
         assign wrk_cur = wrk_ff[s-1];
      end

      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [QuoWidth:0] rs;
         logic [QuoWidth:0] sub;
         logic              take;
         assign rs   = wrk_cur[k][NW-1:QuoWidth-1];
         assign take = (rs >= {1'b0, den_cur});
         assign sub  = rs - {1'b0, den_cur};
         assign wrk_in[k] = {take ? sub[QuoWidth-1:0] : rs[QuoWidth-1:0],
                             wrk_cur[k][QuoWidth-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[s] <= den_cur;
            sb_ff[s]  <= sb_cur;
            wrk_ff[s] <= wrk_in;
         end
      end
   end

   assign out_vld = vld_ff[QuoWidth-1];
   assign out_sb  = sb_ff[QuoWidth-1];
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign out_quo[k] = wrk_ff[QuoWidth-1][k][QuoWidth-1:0];
   end

endmodule

`default_nettype wire

### design/bounding_sphere_merge.sv
// Top level: smallest sphere enclosing two spheres, fully pipelined.
// Depends on bsm_pkg, bsm_isqrt and bsm_div.
//
//  channel | dir | ports                         | payload
//  --------+-----+-------------------------------+----------------------------------
//  req     | in  | req_tvalid/tready/tdata       | two spheres (center xyz, radius)
//  rsp     | out | rsp_tvalid/tready/tdata/tuser | enclosing sphere, merge case code
//
//  One transfer in per clock when the output side keeps up; a result passes the capture,
//  difference, square and sum stages, the one-bit-per-stage square root, the classify and
//  numerator stages, the one-bit-per-stage center divider and the output register.
//  All stages advance together; a stall on rsp freezes every stage, so
//  nothing is lost or repeated, and req_tready drops only while rsp stalls.
//  Synchronous active-high reset clears the valid bits only.
`default_nettype none

module bounding_sphere_merge
   import bsm_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDef
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // first_center_x, first_center_y, first_center_z, first_radius,
   // second_center_x, second_center_y, second_center_z, second_radius
   input  wire logic [8*COORD_WIDTH-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // merged_center_x, merged_center_y, merged_center_z, merged_radius, zero pad
   output logic [((4*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // merge_case
   output logic [2:0]                    rsp_tuser
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;          // center difference magnitude, distance
   localparam int SQW = 2 * DW;         // squares and their sum
   localparam int XW  = W + 3;          // radius/distance compare width
   localparam int OBW = ((4*W+7)/8)*8;

   typedef struct packed {
      logic [2:0][W-1:0]  ac;
      logic [2:0][W-1:0]  bc;
      logic [W-1:0]       ar;
      logic [W-1:0]       br;
      logic [2:0][DW-1:0] dm;
      logic [2:0]         bneg;
      logic               a_emp;
      logic               b_emp;
   } geo_type;

   typedef struct packed {
      logic [2:0][W-1:0] ctr;
      logic [W-1:0]      rad;
      merge_case_type    kase;
      logic [2:0]        bneg;
   } sel_type;

   logic adv;
   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: capture input ----------------
   logic              s0_vld_ff;
   logic [3:0][W-1:0] s0_a_ff, s0_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            s0_a_ff[k] <= req_tdata[k*W +: W];
            s0_b_ff[k] <= req_tdata[(4+k)*W +: W];
         end
      end
   end

   // ---------------- stage 1: differences, empty flags ----------------
   geo_type s1_in, s1_ff;
   logic    s1_vld_ff;

   always_comb begin
      logic signed [DW-1:0] d;
      d = '0;
      s1_in    = '0;
      s1_in.ac = s0_a_ff[2:0];
      s1_in.bc = s0_b_ff[2:0];
      s1_in.ar = s0_a_ff[3];
      s1_in.br = s0_b_ff[3];
      for (int k = 0; k < 3; k++) begin
         d = $signed({s0_b_ff[k][W-1], s0_b_ff[k]}) - $signed({s0_a_ff[k][W-1], s0_a_ff[k]});
         s1_in.bneg[k] = d[DW-1];
         s1_in.dm[k]   = d[DW-1] ? DW'(-d) : DW'(d);
      end
      s1_in.a_emp = s0_a_ff[3][W-1] | (s0_a_ff[3] == '0);
      s1_in.b_emp = s0_b_ff[3][W-1] | (s0_b_ff[3] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- stage 2: squares ----------------
   geo_type             s2_ff;
   logic                s2_vld_ff;
   logic [2:0][SQW-1:0] s2_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s1_ff;
         for (int k = 0; k < 3; k++) begin
            s2_sq_ff[k] <= s1_ff.dm[k] * s1_ff.dm[k];
         end
      end
   end

   // ---------------- stage 3: sum of squares ----------------
   geo_type        s3_ff;
   logic           s3_vld_ff;
   logic [SQW-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff     <= s2_ff;
         s3_sum_ff <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      end
   end

   // ---------------- distance: pipelined square root ----------------
   logic          sq_vld;
   logic [DW-1:0] sq_dist;
   geo_type       sq_geo;

   bsm_isqrt #(
      .RootWidth (DW),
      .SbWidth   ($bits(geo_type))
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (s3_vld_ff),
      .in_x     (s3_sum_ff),
      .in_sb    (s3_ff),
      .out_vld  (sq_vld),
      .out_root (sq_dist),
      .out_sb   (sq_geo)
   );

   // ---------------- stage C: classify, merged radius ----------------
   sel_type           sc_in, sc_ff;
   logic              sc_vld_ff;
   logic [DW-1:0]     sc_dist_ff, sc_num_ff;
   logic [2:0][DW-1:0] sc_dm_ff;
   logic [DW-1:0]     sc_num_in;

   always_comb begin
      logic signed [XW-1:0] ar_e, br_e, dist_e, full;
      logic                 first_holds, second_holds;
      ar_e   = XW'($signed(sq_geo.ar));
      br_e   = XW'($signed(sq_geo.br));
      dist_e = XW'(sq_dist);
      first_holds  = (ar_e >= br_e + dist_e);
      second_holds = (br_e >= ar_e + dist_e);
      full   = (dist_e + ar_e + br_e) >>> 1;
      // never negative and below the distance in the merged case
      sc_num_in = DW'(full - ar_e);

      sc_in      = '0;
      sc_in.bneg = sq_geo.bneg;
      priority if (sq_geo.a_emp) begin
         sc_in.kase = CaseFirstEmpty;
         sc_in.ctr  = sq_geo.bc;
         sc_in.rad  = sq_geo.br;
      end else if (sq_geo.b_emp) begin
         sc_in.kase = CaseSecondEmpty;
         sc_in.ctr  = sq_geo.ac;
         sc_in.rad  = sq_geo.ar;
      end else if (first_holds) begin
         sc_in.kase = CaseFirstContains;
         sc_in.ctr  = sq_geo.ac;
         sc_in.rad  = sq_geo.ar;
      end else if (second_holds) begin
         sc_in.kase = CaseSecondContains;
         sc_in.ctr  = sq_geo.bc;
         sc_in.rad  = sq_geo.br;
      end else begin
         sc_in.kase = CaseMerged;
         sc_in.ctr  = sq_geo.ac;
         // saturate to the largest positive radius
         sc_in.rad  = (full[XW-1:W-1] != '0) ? {1'b0, {(W-1){1'b1}}} : full[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else if (adv) begin
         sc_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff      <= sc_in;
         sc_dist_ff <= sq_dist;
         sc_num_ff  <= sc_num_in;
         sc_dm_ff   <= sq_geo.dm;
      end
   end

   // ---------------- stage M: offset numerators ----------------
   sel_type             sm_ff;
   logic                sm_vld_ff;
   logic [DW-1:0]       sm_dist_ff;
   logic [2:0][SQW-1:0] sm_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else if (adv) begin
         sm_vld_ff <= sc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_ff      <= sc_ff;
         sm_dist_ff <= sc_dist_ff;
         for (int k = 0; k < 3; k++) begin
            sm_prod_ff[k] <= sc_dm_ff[k] * sc_num_ff;
         end
      end
   end

   // ---------------- center offsets: pipelined divide ----------------
   logic               dv_vld;
   logic [2:0][DW-1:0] dv_off;
   sel_type            dv_sel;

   bsm_div #(
      .QuoWidth (DW),
      .SbWidth  ($bits(sel_type))
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (sm_vld_ff),
      .in_num  (sm_prod_ff),
      .in_den  (sm_dist_ff),
      .in_sb   (sm_ff),
      .out_vld (dv_vld),
      .out_quo (dv_off),
      .out_sb  (dv_sel)
   );

   // ---------------- output register ----------------
   logic              rsp_vld_ff;
   logic [2:0][W-1:0] rsp_ctr_ff, rsp_ctr_in;
   logic [W-1:0]      rsp_rad_ff;
   logic [2:0]        rsp_case_ff;

   always_comb begin
      logic signed [DW:0] base, moved;
      base  = '0;
      moved = '0;
      rsp_ctr_in = dv_sel.ctr;
      if (dv_sel.kase == CaseMerged) begin
         for (int k = 0; k < 3; k++) begin
            base  = (DW+1)'($signed(dv_sel.ctr[k]));
            moved = dv_sel.bneg[k] ? base - $signed({1'b0, dv_off[k]})
                                   : base + $signed({1'b0, dv_off[k]});
            rsp_ctr_in[k] = moved[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ctr_ff  <= rsp_ctr_in;
         rsp_rad_ff  <= dv_sel.rad;
         rsp_case_ff <= dv_sel.kase;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OBW'({rsp_rad_ff, rsp_ctr_ff[2], rsp_ctr_ff[1], rsp_ctr_ff[0]});
   assign rsp_tuser  = rsp_case_ff;

endmodule

`default_nettype wire

### design/bsm_checker.sv
// Port-level checks for bounding_sphere_merge, attached by bind.
// Depends on bsm_pkg.
`default_nettype none

module bsm_checker
   import bsm_pkg::*;
#(
   parameter int CoordWidth = CoordWidthDef
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [((4*CoordWidth+7)/8)*8-1:0]  rsp_tdata,
   input wire logic [2:0]                         rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transfer dropped while stalled");

   // and keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // input side stalls only while the output side does
   a_req_ready : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   a_case_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= 3'(CaseMerged))
      else $error("merge case code out of range");

   // a merged sphere never has a negative radius
   a_merged_rad : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 3'(CaseMerged) |-> !rsp_tdata[4*CoordWidth-1])
      else $error("merged radius negative");

endmodule

bind bounding_sphere_merge bsm_checker #(.CoordWidth(COORD_WIDTH)) u_bsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
